// ===== rtl/xcfr_pkg.sv =====
`timescale 1ns / 1ps
package xcfr_pkg;

	localparam int MAX_PAYLOAD = 16;
	localparam int IDX_W       = $clog2(MAX_PAYLOAD);
	localparam int LEN_W       = IDX_W + 1;

	localparam logic [7:0] SYNC_BYTE = 8'h06;

	localparam logic [LEN_W-1:0] EXP_LEN_RST  = LEN_W'(1);
	localparam logic [7:0]       ACC_TYPE_RST = 8'd133;

	// register indexes
	localparam logic REG_EXP_LEN  = 1'b0;
	localparam logic REG_ACC_TYPE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_GOOD = 2'd0;
	localparam logic [1:0] ST_TYPE = 2'd1;
	localparam logic [1:0] ST_LEN  = 2'd2;
	localparam logic [1:0] ST_CSUM = 2'd3;

	typedef enum logic [2:0] {
		S_HUNT,
		S_TYPE,
		S_LEN,
		S_DATA,
		S_CHECK,
		S_EMIT
	} phase_t;

	typedef struct packed {
		logic       load_len;   // length byte accepted, start payload
		logic       store;      // payload word accepted
		logic       clr;        // back to hunting
		logic       emit_err;
		logic [1:0] err_code;
		logic       emit_good;
	} cmd_t;

	typedef struct packed {
		logic is_sync;
		logic type_ok;
		logic len_ok;
		logic fill_done;
		logic csum_ok;
		logic out_free;
		logic emit_last;
	} stat_t;

endpackage

// ===== rtl/xcfr_ctrl.sv =====
`timescale 1ns / 1ps
module xcfr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  xcfr_pkg::stat_t stat,
	output xcfr_pkg::cmd_t  cmd
);

	xcfr_pkg::phase_t state_q, state_d;
	logic acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= xcfr_pkg::S_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q != xcfr_pkg::S_EMIT) && stat.out_free;
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			xcfr_pkg::S_HUNT: begin
				if (acc && stat.is_sync) begin
					state_d = xcfr_pkg::S_TYPE;
				end
			end
			xcfr_pkg::S_TYPE: begin
				if (acc) begin
					if (stat.type_ok) begin
						state_d = xcfr_pkg::S_LEN;
					end else begin
						cmd.emit_err = 1'b1;
						cmd.err_code = xcfr_pkg::ST_TYPE;
						cmd.clr      = 1'b1;
						state_d      = xcfr_pkg::S_HUNT;
					end
				end
			end
			xcfr_pkg::S_LEN: begin
				if (acc) begin
					if (stat.len_ok) begin
						cmd.load_len = 1'b1;
						state_d      = xcfr_pkg::S_DATA;
					end else begin
						cmd.emit_err = 1'b1;
						cmd.err_code = xcfr_pkg::ST_LEN;
						cmd.clr      = 1'b1;
						state_d      = xcfr_pkg::S_HUNT;
					end
				end
			end
			xcfr_pkg::S_DATA: begin
				if (acc) begin
					cmd.store = 1'b1;
					if (stat.fill_done) begin
						state_d = xcfr_pkg::S_CHECK;
					end
				end
			end
			xcfr_pkg::S_CHECK: begin
				if (acc) begin
					if (stat.csum_ok) begin
						state_d = xcfr_pkg::S_EMIT;
					end else begin
						cmd.emit_err = 1'b1;
						cmd.err_code = xcfr_pkg::ST_CSUM;
						cmd.clr      = 1'b1;
						state_d      = xcfr_pkg::S_HUNT;
					end
				end
			end
			xcfr_pkg::S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_good = 1'b1;
					if (stat.emit_last) begin
						cmd.clr = 1'b1;
						state_d = xcfr_pkg::S_HUNT;
					end
				end
			end
			default: begin
				cmd.clr = 1'b1;
				state_d = xcfr_pkg::S_HUNT;
			end
		endcase
	end

	a_no_input_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == xcfr_pkg::S_EMIT |-> !in_ready)
		else $error("input accepted while draining a frame");

	a_err_returns_to_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_err |=> state_q == xcfr_pkg::S_HUNT)
		else $error("error word did not return to hunt");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.emit_err && cmd.emit_good))
		else $error("two loads of the output register in one cycle");

endmodule

// ===== rtl/xcfr_dp.sv =====
`timescale 1ns / 1ps
module xcfr_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [7:0]                 rx_byte,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data,
	input  xcfr_pkg::cmd_t             cmd,
	output xcfr_pkg::stat_t            stat,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [7:0]                 payload_byte,
	output logic [xcfr_pkg::IDX_W-1:0] byte_index,
	output logic                       last
);

	logic [xcfr_pkg::LEN_W-1:0] exp_len_q;
	logic [7:0]                 acc_type_q;
	logic [xcfr_pkg::LEN_W-1:0] decl_len_q;
	logic [xcfr_pkg::LEN_W-1:0] fill_q;
	logic [7:0]                 xor_q;
	logic [xcfr_pkg::IDX_W-1:0] emit_idx_q;
	logic [7:0]                 store_q [xcfr_pkg::MAX_PAYLOAD];
	logic                       out_valid_q;
	logic [1:0]                 status_q;
	logic [7:0]                 payload_q;
	logic [xcfr_pkg::IDX_W-1:0] index_q;
	logic                       last_q;
	logic [xcfr_pkg::LEN_W-1:0] fill_inc;
	logic [xcfr_pkg::LEN_W-1:0] emit_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q  <= xcfr_pkg::EXP_LEN_RST;
			acc_type_q <= xcfr_pkg::ACC_TYPE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				xcfr_pkg::REG_EXP_LEN:  exp_len_q  <= cfg_data[xcfr_pkg::LEN_W-1:0];
				xcfr_pkg::REG_ACC_TYPE: acc_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign fill_inc = fill_q + 1'b1;
	assign emit_cnt = {1'b0, emit_idx_q} + 1'b1;

	always_comb begin
		stat.is_sync   = rx_byte == xcfr_pkg::SYNC_BYTE;
		stat.type_ok   = rx_byte == acc_type_q;
		stat.len_ok    = (rx_byte == 8'(exp_len_q)) && (rx_byte != 8'd0)
			&& (rx_byte <= 8'(xcfr_pkg::MAX_PAYLOAD));
		stat.fill_done = fill_inc >= decl_len_q;
		stat.csum_ok   = rx_byte == xor_q;
		stat.out_free  = !out_valid_q || out_ready;
		stat.emit_last = emit_cnt == decl_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_len_q <= '0;
			fill_q     <= '0;
			xor_q      <= '0;
			emit_idx_q <= '0;
		end else if (cmd.clr) begin
			decl_len_q <= '0;
			fill_q     <= '0;
			xor_q      <= '0;
			emit_idx_q <= '0;
		end else if (cmd.load_len) begin
			decl_len_q <= rx_byte[xcfr_pkg::LEN_W-1:0];
			fill_q     <= '0;
			xor_q      <= rx_byte;
			emit_idx_q <= '0;
		end else begin
			if (cmd.store) begin
				fill_q <= fill_inc;
				xor_q  <= xor_q ^ rx_byte;
			end
			if (cmd.emit_good) begin
				emit_idx_q <= emit_idx_q + 1'b1;
			end
		end
	end

	// payload store, no reset: only entries of the current frame are read
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[fill_q[xcfr_pkg::IDX_W-1:0]] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_err || cmd.emit_good) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_err) begin
			status_q  <= cmd.err_code;
			payload_q <= '0;
			index_q   <= '0;
			last_q    <= 1'b1;
		end else if (cmd.emit_good) begin
			status_q  <= xcfr_pkg::ST_GOOD;
			payload_q <= store_q[emit_idx_q];
			index_q   <= emit_idx_q;
			last_q    <= stat.emit_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign payload_byte = payload_q;
	assign byte_index   = index_q;
	assign last         = last_q;

endmodule

// ===== rtl/xor_checked_frame_receiver.sv =====
`timescale 1ns / 1ps
// Frame receiver for a byte stream: sync 0x06, type, length, payload, XOR
// checksum over length and payload. Each received word is taken whenever
// the receiver is not draining a frame and the output register is empty or
// being emptied. A good frame of N payload bytes is then drained as N
// result words, one per cycle while the output register is free, from the
// single read port of the payload store, and input is held off while they
// drain. Error words (wrong type, wrong length, bad checksum) are loaded in
// the same cycle as the offending byte and the receiver is hunting for sync
// again at once.
// Register 0 is the expected length (5 bits), register 1 the accepted
// type byte; write them only while idle.
module xor_checked_frame_receiver (
	input  logic                       clk,
	input  logic                       arst_n,
	// received bytes
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [7:0]                 rx_byte,
	// results
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 status,
	output logic [7:0]                 payload_byte,
	output logic [xcfr_pkg::IDX_W-1:0] byte_index,
	output logic                       last,
	// register writes
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [7:0]                 cfg_data
);

	xcfr_pkg::cmd_t  cmd;
	xcfr_pkg::stat_t stat;

	// phase sequencing
	xcfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// compares, running XOR, payload store, output register
	xcfr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx_byte      (rx_byte),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.payload_byte (payload_byte),
		.byte_index   (byte_index),
		.last         (last)
	);

endmodule
